// File: rtl/core/bdtg_pkg.sv
// Shared types and constants for the balanced-duration tone generator.
// Holds command codes, register indexes, field widths, the queue item types,
// the back-end state encoding and the sine-table construction constants.
package bdtg_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned FREQ_W     = 15;
	localparam int unsigned DUR_W      = 24;
	localparam int unsigned PER_W      = 16;
	localparam int unsigned GAIN_W     = 40;
	localparam int unsigned AMP_W      = 15;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned PHASE_W    = 32;
	localparam int unsigned ERR_W      = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 40;
	// Dividend of the count division: duration plus half a period.
	localparam int unsigned NUM_W      = 25;

	// Input command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP    = 2'd2;

	// Register reset values.
	localparam logic [PER_W-1:0]  PERIOD_RST = 16'd2000;
	localparam logic [GAIN_W-1:0] GAIN_RST   = 40'd4398046511;
	localparam logic [AMP_W-1:0]  AMP_RST    = 15'd25000;

	localparam logic [DUR_W-1:0] COUNT_MAX = '1;

	// Sine table construction: Q30 fixed point Taylor series.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned TAYLOR_DIV [10] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
		  64'd420};

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TICK,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} cmd_item_t;

	typedef struct packed {
		logic      valid;
		cmd_item_t item;
	} cmd_req_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ROM,
		BK_MUL,
		BK_OUT,
		BK_PLO,
		BK_PHI,
		BK_DIV,
		BK_CPM,
		BK_ERR
	} bk_state_t;

endpackage

// File: rtl/core/bdtg_front.sv
// Front end of the tone generator: accepts input transfers, classifies the
// command and queues useful items in a two-entry queue. Depends on bdtg_pkg.
module bdtg_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bdtg_pkg::CMD_W-1:0]  command,
	input  logic [bdtg_pkg::FREQ_W-1:0] tone_frequency,
	input  logic [bdtg_pkg::DUR_W-1:0]  tone_duration,
	output bdtg_pkg::cmd_req_t          req,
	input  logic                        pop
);
	import bdtg_pkg::*;

	cmd_item_t  q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	op_t        op;
	logic       push;

	// Unknown commands are taken and dropped here so the back end never sees them.
	always_comb begin
		keep = 1'b1;
		op   = OP_TICK;
		unique case (command)
			CMD_LOAD:  op = OP_LOAD;
			CMD_TICK:  op = OP_TICK;
			CMD_CLEAR: op = OP_CLEAR;
			default:   keep = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && keep;

	assign req.valid = (cnt_q != 2'd0);
	assign req.item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{op: op, freq: tone_frequency, dur: tone_duration};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/core/bdtg_div.sv
// Restoring divider for the tone sample count, one quotient bit per cycle.
// Depends on bdtg_pkg for the operand widths.
module bdtg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bdtg_pkg::NUM_W-1:0]  numer,
	input  logic [bdtg_pkg::PER_W-1:0]  denom,
	output logic                        busy,
	output logic [bdtg_pkg::NUM_W-1:0]  quot
);
	import bdtg_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [PER_W-1:0] den_q;
	logic [PER_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [PER_W:0]   trial;
	logic             ge;
	logic [PER_W:0]   diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	// The remainder stays below the divisor, so it always fits the divisor width.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule

// File: rtl/core/bdtg_back.sv
// Back end of the tone generator: executes queued loads, ticks and clears,
// owns the oscillator state, the sine table and the output register.
// Depends on bdtg_pkg and instantiates bdtg_div.
module bdtg_back #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdtg_pkg::cmd_req_t            req,
	output logic                          pop,
	input  logic [bdtg_pkg::PER_W-1:0]    sample_period,
	input  logic [bdtg_pkg::GAIN_W-1:0]   phase_gain,
	input  logic [bdtg_pkg::AMP_W-1:0]    amplitude,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bdtg_pkg::SAMPLE_W-1:0] sample,
	output logic                          last_of_tone
);
	import bdtg_pkg::*;

	localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH);
	localparam logic signed [41:0] ERR_HI = 42'sd2147483647;
	localparam logic signed [41:0] ERR_LO = -42'sd2147483648;

	// Quarter-wave entry k in Q30, evaluated at elaboration.
	function automatic logic [30:0] sine_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 10; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TAYLOR_DIV[n-1];
			if ((n & 1) != 0) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(ONE_Q30)) begin
			acc = longint'(ONE_Q30);
		end
		return 31'(acc);
	endfunction

	logic [30:0] rom_table [SINE_TABLE_DEPTH+1];

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign rom_table[g] = sine_entry(g);
	end

	bk_state_t state_q, state_d;

	// Oscillator state.
	logic [PHASE_W-1:0]      phase_q;
	logic [PHASE_W-1:0]      step_q;
	logic [DUR_W-1:0]        left_q;
	logic signed [ERR_W-1:0] err_q;

	// Work registers of the tick and load sequences.
	logic [AW-1:0]       addr_q;
	logic                neg_q;
	logic                last_q;
	logic [30:0]         entry_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [DUR_W-1:0]    dur_q;
	logic [34:0]         plo_q;
	logic [34:0]         phi_q;
	logic [DUR_W-1:0]    count_q;
	logic [39:0]         cpm_q;
	logic [PHASE_W-1:0]  step_nq;

	// Output register.
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                last_out_q;

	logic             div_start;
	logic             div_busy;
	logic [NUM_W-1:0] div_quot;
	logic [NUM_W-1:0] div_numer;

	logic                is_tick;
	logic                is_load;
	logic                is_clear;
	logic                out_free;
	logic                out_load;

	// Tick arithmetic.
	logic [29+AW:0]          idx_prod;
	logic [IW-1:0]           idx;
	logic [AW-1:0]           addr_d;
	logic [DUR_W-1:0]        left_m1;
	logic [DUR_W-1:0]        left_d;
	logic signed [ERR_W:0]   diff33;
	logic signed [ERR_W:0]   per33;
	logic                    over;
	logic                    under;
	logic signed [ERR_W:0]   err_tick;
	logic signed [ERR_W-1:0] err_tick_d;
	logic [45:0]             mag_prod;

	// Load arithmetic.
	logic [DUR_W-1:0]  count_d;
	logic [47:0]       step_sum;
	logic signed [41:0] err_sum;
	logic signed [ERR_W-1:0] err_load_d;

	assign is_tick  = req.valid && (req.item.op == OP_TICK);
	assign is_load  = req.valid && (req.item.op == OP_LOAD);
	assign is_clear = req.valid && (req.item.op == OP_CLEAR);
	assign out_free = !out_valid_q || out_ready;

	assign div_numer = {1'b0, req.item.dur} + {10'b0, sample_period[PER_W-1:1]};

	bdtg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (sample_period),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Table address: the top two phase bits pick the quadrant, odd quadrants mirror.
	always_comb begin
		idx_prod = (30+AW)'(phase_q[29:0]) * (30+AW)'(SINE_TABLE_DEPTH);
		idx      = idx_prod[30 +: IW];
		if (phase_q[30]) begin
			addr_d = AW'(SINE_TABLE_DEPTH) - AW'(idx);
		end else begin
			addr_d = AW'(idx);
		end
	end

	// Countdown with drift balancing; at most one of the two corrections applies.
	always_comb begin
		left_m1  = left_q - 1'b1;
		diff33   = (ERR_W+1)'(err_q);
		per33    = $signed({17'b0, sample_period});
		over     = diff33 > per33;
		under    = diff33 < -per33;
		left_d   = left_m1;
		err_tick = diff33;
		if (over) begin
			if (left_m1 != '0) begin
				left_d = left_m1 - 1'b1;
			end
			err_tick = diff33 - per33;
		end
		if (under) begin
			if (left_m1 != COUNT_MAX) begin
				left_d = left_m1 + 1'b1;
			end
			err_tick = diff33 + per33;
		end
		err_tick_d = err_tick[ERR_W-1:0];
	end

	assign mag_prod = 46'(amplitude) * 46'(entry_q);

	always_comb begin
		if (sample_period == '0) begin
			count_d = '0;
		end else if (div_quot > NUM_W'(COUNT_MAX)) begin
			count_d = COUNT_MAX;
		end else begin
			count_d = div_quot[DUR_W-1:0];
		end
		step_sum = {phi_q[27:0], 20'b0} + {13'b0, plo_q} + 48'h8000;
		err_sum  = 42'(err_q) + $signed({2'b0, cpm_q}) - $signed({18'b0, dur_q});
		if (err_sum > ERR_HI) begin
			err_load_d = ERR_HI[ERR_W-1:0];
		end else if (err_sum < ERR_LO) begin
			err_load_d = ERR_LO[ERR_W-1:0];
		end else begin
			err_load_d = err_sum[ERR_W-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (req.valid) begin
					pop = 1'b1;
				end
				if (is_tick && (left_q != '0)) begin
					state_d = BK_ROM;
				end
				if (is_load) begin
					div_start = 1'b1;
					state_d   = BK_PLO;
				end
			end
			BK_ROM: state_d = BK_MUL;
			BK_MUL: state_d = BK_OUT;
			BK_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			BK_PLO: state_d = BK_PHI;
			BK_PHI: state_d = BK_DIV;
			BK_DIV: begin
				if (!div_busy) begin
					state_d = BK_CPM;
				end
			end
			BK_CPM: state_d = BK_ERR;
			BK_ERR: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			left_q  <= '0;
			err_q   <= '0;
		end else begin
			if (state_q == BK_IDLE && is_tick && left_q != '0) begin
				phase_q <= phase_q + step_q;
				left_q  <= left_d;
				err_q   <= err_tick_d;
			end
			if (state_q == BK_IDLE && is_clear) begin
				err_q <= '0;
			end
			if (state_q == BK_ERR) begin
				step_q <= step_nq;
				left_q <= count_q;
				err_q  <= err_load_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				addr_q <= addr_d;
				neg_q  <= phase_q[31];
				last_q <= (left_d == '0);
				freq_q <= req.item.freq;
				dur_q  <= req.item.dur;
			end
			BK_ROM: entry_q <= rom_table[addr_q];
			BK_MUL: mag_q   <= mag_prod[45:30];
			BK_PLO: plo_q   <= 35'(freq_q) * 35'(phase_gain[19:0]);
			BK_PHI: phi_q   <= 35'(freq_q) * 35'(phase_gain[39:20]);
			BK_CPM: begin
				count_q <= count_d;
				cpm_q   <= 40'(count_d) * 40'(sample_period);
				step_nq <= step_sum[47:16];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q   <= neg_q ? (SAMPLE_W'(0) - mag_q) : mag_q;
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = sample_q;
	assign last_of_tone = last_out_q;

endmodule

// File: rtl/core/balanced_duration_tone_generator.sv
// Top level of the balanced-duration tone generator.
// Holds the configuration registers and connects bdtg_front to bdtg_back.
// Depends on bdtg_pkg, bdtg_front, bdtg_back and bdtg_div.

// This block is a phase-continuous sine oscillator for audio tones. A load
// command (0) sets the phase step from the frequency and the sample count from
// round(duration / sample_period), and adds the rounding error of that count
// to a running balance. Each tick command (1) emits one sample of
// amplitude * sin(phase) and advances the phase; when the balance exceeds one
// sample period, the tone is shortened or lengthened by a sample so that a
// series of tones keeps its overall timing. Command 2 clears the balance, and
// command 3 is taken and ignored. A tick after the tone has ended produces no
// output transfer, and the last sample of a tone carries last_of_tone. Input
// transfers go into a two-entry queue, so the producer can run ahead while the
// back end works and while a finished sample waits in the output register.
// The back end executes one command at a time: a tick that emits a sample
// passes through table address, registered table read, amplitude multiply
// and output register, waiting for a free output register; clear and ticks
// of an ended tone are handled in the idle state, and a load waits for the
// 25-step restoring divider that computes the sample count. Configuration
// writes (0 sample_period, 1 phase_gain, 2 amplitude) are always accepted
// and must only be made while the block is idle; writes to index 3 are
// ignored. SINE_TABLE_DEPTH sets the number of quarter-wave table steps; the
// table is built at elaboration.
module balanced_duration_tone_generator #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bdtg_pkg::CMD_W-1:0]      command,
	input  logic [bdtg_pkg::FREQ_W-1:0]     tone_frequency,
	input  logic [bdtg_pkg::DUR_W-1:0]      tone_duration,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bdtg_pkg::SAMPLE_W-1:0]   sample,
	output logic                            last_of_tone,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bdtg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdtg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdtg_pkg::*;

	logic [PER_W-1:0]  period_q;
	logic [GAIN_W-1:0] gain_q;
	logic [AMP_W-1:0]  amp_q;
	cmd_req_t          req;
	logic              pop;

	// The register file never stalls a configuration transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			gain_q   <= GAIN_RST;
			amp_q    <= AMP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PER_W-1:0];
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_AMP:    amp_q    <= cfg_data[AMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bdtg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.tone_frequency (tone_frequency),
		.tone_duration  (tone_duration),
		.req            (req),
		.pop            (pop)
	);

	bdtg_back #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.pop           (pop),
		.sample_period (period_q),
		.phase_gain    (gain_q),
		.amplitude     (amp_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample        (sample),
		.last_of_tone  (last_of_tone)
	);

endmodule

// File: rtl/core/bdtg_checker.sv
// Port-level checker for the tone generator, bound to the top level.
// Depends on bdtg_pkg for widths and command codes.
module bdtg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [bdtg_pkg::CMD_W-1:0]      command,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [bdtg_pkg::SAMPLE_W-1:0]   sample,
	input logic                            last_of_tone,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);
	import bdtg_pkg::*;

	// Ticks accepted but not yet answered by a sample; sticks once it saturates.
	logic [15:0] pend_q;
	logic        tick_acc;
	logic        out_acc;

	assign tick_acc = in_valid && in_ready && (command == CMD_TICK);
	assign out_acc  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pend_q != '1) begin
			pend_q <= pend_q + {15'b0, tick_acc} - {15'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sample withdrawn before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample) && $stable(last_of_tone))
		else $error("sample payload changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != '0)
		else $error("sample transferred without a pending tick");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind balanced_duration_tone_generator bdtg_checker u_bdtg_checker (.*);

// File: tb/sv/balanced_duration_tone_generator_tb.sv
// Self-checking testbench for the balanced-duration tone generator.
// Drives commands and register writes, predicts every sample and compares it.
// Depends on bdtg_pkg and balanced_duration_tone_generator.
module balanced_duration_tone_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdtg_pkg::*;

	localparam int unsigned TABLE_DEPTH   = 256;
	localparam int unsigned HALF_CLK      = 4;
	localparam int unsigned RESET_CYCLES  = 7;
	// A load spends most of its time in the divider, and up to two more commands
	// can sit in the input queue behind it, so this covers everything still in flight.
	localparam int unsigned SETTLE_CYCLES = 128;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned HOLD_STEP     = 150;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned MAX_PRINTS    = 40;

	// Command code 3 and register index 3 have no function; the block drops them.
	localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam longint DRIFT_MAX = 64'sd2147483647;
	localparam longint DRIFT_MIN = -64'sd2147483648;

	typedef struct {
		logic [CMD_W-1:0]  code;
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} tone_cmd_t;

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} tone_sample_t;

	// Every input of the block starts at a known value.
	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_ready;
	logic [CMD_W-1:0]      command        = '0;
	logic [FREQ_W-1:0]     tone_frequency = '0;
	logic [DUR_W-1:0]      tone_duration  = '0;
	logic                  out_valid;
	logic                  out_ready      = 1'b0;
	logic [SAMPLE_W-1:0]   sample;
	logic                  last_of_tone;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	// Predictor copy of the registers and of the oscillator state.
	logic [PER_W-1:0]          model_period;
	logic [GAIN_W-1:0]         model_gain;
	logic [AMP_W-1:0]          model_amp;
	logic [PHASE_W-1:0]        tone_phase;
	logic [PHASE_W-1:0]        tone_step;
	logic [DUR_W-1:0]          tone_left;
	logic signed [ERR_W-1:0]   drift;
	logic [31:0]               sine_q30 [0:TABLE_DEPTH];

	tone_cmd_t    cmd_backlog[$];
	tone_sample_t expected_samples[$];

	int unsigned errors     = 0;
	int unsigned cycles     = 0;
	int unsigned cmds_taken = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left  = 0;
	int unsigned in_gap     = 0;
	int unsigned out_gap    = 0;
	bit          in_calm    = 1'b0;
	bit          out_calm   = 1'b0;
	logic        in_done    = 1'b0;
	logic        out_done   = 1'b0;

	balanced_duration_tone_generator #(
		.SINE_TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.tone_frequency(tone_frequency),
		.tone_duration (tone_duration),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample        (sample),
		.last_of_tone  (last_of_tone),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(HALF_CLK) clk = ~clk;

	// Quarter-wave table in Q30: a Taylor series of sin(x) up to the x^21 term with every
	// product and quotient truncated, clamped to the range 0 to 1.0.
	function automatic void build_sine_table();
		longint unsigned x;
		longint unsigned term;
		longint unsigned divisor;
		longint          acc;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			x = (HALF_PI_Q30 * 64'(k)) / 64'(TABLE_DEPTH);
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 10; n++) begin
				term = (((term * x) >> 30) * x) >> 30;
				divisor = 64'(2 * n) * 64'(2 * n + 1);
				term = term / divisor;
				if (n % 2 == 1) begin
					acc -= longint'(term);
				end else begin
					acc += longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > longint'(ONE_Q30)) begin
				acc = longint'(ONE_Q30);
			end
			sine_q30[k] = acc[31:0];
		end
	endfunction

	// Quadrant 1 and 3 mirror the table index, quadrants 2 and 3 flip the sign.
	function automatic logic [SAMPLE_W-1:0] sine_of(logic [PHASE_W-1:0] ph);
		longint unsigned slot;
		longint unsigned entry;
		longint unsigned mag;
		slot = ({34'd0, ph[29:0]} * 64'(TABLE_DEPTH)) >> 30;
		entry = ph[30] ? 64'(sine_q30[TABLE_DEPTH - slot]) : 64'(sine_q30[slot]);
		mag = (64'(model_amp) * entry) >> 30;
		if (ph[31]) begin
			mag = 64'd0 - mag;
		end
		return mag[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [ERR_W-1:0] clamp_drift(longint v);
		if (v > DRIFT_MAX) begin
			v = DRIFT_MAX;
		end
		if (v < DRIFT_MIN) begin
			v = DRIFT_MIN;
		end
		return v[ERR_W-1:0];
	endfunction

	// Advances the predicted oscillator by one accepted command and queues the
	// sample that a tick of a running tone must produce.
	function automatic void run_tone_model(tone_cmd_t c);
		longint       per;
		longint       count;
		longint       d;
		tone_sample_t res;
		per = longint'(model_period);
		case (c.code)
			CMD_LOAD: begin
				// Round to the nearest sample count, halves up; a zero period gives
				// an empty tone but the whole duration still goes into the drift.
				count = (per == 0) ? 0 : (longint'(c.dur) + per / 2) / per;
				if (count > longint'(COUNT_MAX)) begin
					count = longint'(COUNT_MAX);
				end
				tone_step = PHASE_W'((64'(c.freq) * 64'(model_gain) + 64'h8000) >> 16);
				tone_left = count[DUR_W-1:0];
				drift = clamp_drift(longint'(drift) + count * per - longint'(c.dur));
			end
			CMD_TICK: begin
				if (tone_left != 0) begin
					d = longint'(drift);
					res.value = sine_of(tone_phase);
					tone_phase = tone_phase + tone_step;
					tone_left = tone_left - 1'b1;
					// More than a period ahead: drop a sample if one is left; the drift is corrected either way.
					if (d > per) begin
						if (tone_left != 0) begin
							tone_left = tone_left - 1'b1;
						end
						drift = clamp_drift(d - per);
					end
					// More than a period behind: add a sample.
					if (d < -per) begin
						if (tone_left != COUNT_MAX) begin
							tone_left = tone_left + 1'b1;
						end
						drift = clamp_drift(d + per);
					end
					res.last = (tone_left == 0);
					expected_samples.push_back(res);
				end
			end
			CMD_CLEAR: begin
				drift = '0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		if (errors < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		errors++;
	endtask

	function automatic void queue_cmd(logic [CMD_W-1:0] code, logic [FREQ_W-1:0] freq,
			logic [DUR_W-1:0] dur);
		tone_cmd_t c;
		c.code = code;
		c.freq = freq;
		c.dur = dur;
		cmd_backlog.push_back(c);
	endfunction

	// Mostly whole tones: a load whose duration lands near a small multiple of the
	// current period, followed by about that many ticks, sometimes a few more so
	// that ticks run past the end. Clears, bare ticks, loads with any duration and
	// the unused command are mixed in. The unused command does not count.
	task automatic queue_random_tones(int n);
		int unsigned pick;
		int unsigned ticks;
		longint      per;
		longint      dur;
		per = longint'(model_period);
		while (n > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				queue_cmd(CMD_UNUSED, FREQ_W'($urandom), DUR_W'($urandom));
			end else if (pick < 11) begin
				queue_cmd(CMD_CLEAR, FREQ_W'($urandom), DUR_W'($urandom));
				n--;
			end else if (pick < 17) begin
				queue_cmd(CMD_LOAD, FREQ_W'($urandom), DUR_W'($urandom));
				n--;
			end else if (pick < 23) begin
				queue_cmd(CMD_TICK, FREQ_W'($urandom), DUR_W'($urandom));
				n--;
			end else begin
				ticks = $urandom_range(0, 6);
				dur = per * ticks + longint'($urandom_range(0, per)) - per / 2;
				if (per == 0) begin
					dur = longint'($urandom_range(0, 4000));
				end
				if (dur < 0) begin
					dur = 0;
				end
				queue_cmd(CMD_LOAD, FREQ_W'($urandom), dur[DUR_W-1:0]);
				ticks += $urandom_range(0, 2);
				repeat (ticks) queue_cmd(CMD_TICK, FREQ_W'($urandom), DUR_W'($urandom));
				n -= 1 + ticks;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [PER_W-1:0] per, logic [GAIN_W-1:0] gain,
			logic [AMP_W-1:0] amp);
		write_reg(REG_PERIOD, CFG_DATA_W'(per));
		write_reg(REG_GAIN, gain);
		write_reg(REG_AMP, CFG_DATA_W'(amp));
	endtask

	// Returns once every queued command has been taken and every predicted sample
	// has come back, plus enough cycles for a trailing load to leave the divider.
	task automatic wait_for_idle();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || expected_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Input driver. A new command goes out at the falling edge after the previous
	// transfer, once the idle cycles drawn for it have passed. The idle count is
	// drawn per command, and now and then the driver switches into a calm mode in
	// which it sends back to back.
	always @(negedge clk) begin
		tone_cmd_t next_cmd;
		if (arst_n && (!in_valid || in_done)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (cmd_backlog.size() != 0) begin
				next_cmd = cmd_backlog.pop_front();
				command <= next_cmd.code;
				tone_frequency <= next_cmd.freq;
				tone_duration <= next_cmd.dur;
				in_valid <= 1'b1;
				if ($urandom_range(0, 15) == 0) begin
					in_calm = !in_calm;
				end
				in_gap <= in_calm ? 0 : $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Sample receiver. After each output transfer it draws how many cycles to
	// hold ready low; during a long hold-off it refuses everything.
	always @(negedge clk) begin
		int unsigned gap;
		gap = out_gap;
		if (out_done) begin
			if ($urandom_range(0, 15) == 0) begin
				out_calm = !out_calm;
			end
			gap = out_calm ? 0 : $urandom_range(0, 3);
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
		end else if (gap != 0) begin
			out_ready <= 1'b0;
			gap--;
		end else begin
			out_ready <= 1'b1;
		end
		out_gap = gap;
	end

	// Twice during the run the receiver stops for a long stretch while the driver
	// keeps sending commands, so the output register and the input queue fill up and
	// the block has to push back on its input.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && cmds_taken >= HOLD_STEP * (holds_done * 2 + 1)) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Everything that happens at the rising edge: register writes and command
	// transfers update the predictor, and sample transfers are checked against the
	// oldest prediction. The cycle counter ends a run that hangs.
	always @(posedge clk) begin
		tone_cmd_t    taken;
		tone_sample_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("balanced_duration_tone_generator test failed");
			$finish;
		end else begin
			in_done <= arst_n && in_valid && in_ready;
			out_done <= arst_n && out_valid && out_ready;
			if (arst_n && cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PERIOD: model_period = cfg_data[PER_W-1:0];
					REG_GAIN:   model_gain = cfg_data[GAIN_W-1:0];
					REG_AMP:    model_amp = cfg_data[AMP_W-1:0];
					default: begin
					end
				endcase
			end
			if (arst_n && in_valid && in_ready) begin
				taken.code = command;
				taken.freq = tone_frequency;
				taken.dur = tone_duration;
				run_tone_model(taken);
				cmds_taken++;
			end
			if (arst_n && out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d arrived with none expected",
						$signed(sample)));
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want.value) begin
						report_mismatch($sformatf("sample %0d, expected %0d",
							$signed(sample), $signed(want.value)));
					end
					if (last_of_tone !== want.last) begin
						report_mismatch($sformatf("last_of_tone %b, expected %b",
							last_of_tone, want.last));
					end
				end
			end
		end
	end

	initial begin
		build_sine_table();
		model_period = PERIOD_RST;
		model_gain = GAIN_RST;
		model_amp = AMP_RST;
		tone_phase = '0;
		tone_step = '0;
		tone_left = '0;
		drift = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset registers (period 2000).
		// A tick before any tone, then the unused command with every field bit set.
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_UNUSED, '1, '1);
		// Largest frequency and duration, then a tone at the largest meaningful
		// duration that replaces it while the phase keeps running.
		queue_cmd(CMD_LOAD, '1, '1);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_TICK, '1, '1);
		queue_cmd(CMD_LOAD, '0, 24'd16000000);
		queue_cmd(CMD_TICK, '0, '0);
		// An empty tone: its tick gives nothing.
		queue_cmd(CMD_LOAD, '0, '0);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_CLEAR, '0, '0);
		// Three half-period durations round up and push the drift past a period,
		// so the single sample of the last tone is also a drop at the end.
		repeat (3) queue_cmd(CMD_LOAD, 15'd1234, 24'd1000);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_CLEAR, '0, '0);
		// The opposite way: the drift falls below minus a period and a sample is added.
		repeat (3) queue_cmd(CMD_LOAD, 15'd4321, 24'd2999);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_LOAD, 15'h4000, 24'd2000);
		queue_cmd(CMD_TICK, '0, '0);
		wait_for_idle();

		// Short period (125), smallest nonzero gain and zero amplitude.
		configure(16'd125, 40'd1, '0);
		queue_random_tones(40);
		wait_for_idle();

		// Largest period, gain and amplitude.
		configure('1, '1, '1);
		queue_random_tones(100);
		wait_for_idle();

		// Zero period: every tone is empty, and maximal loads drive the drift into
		// its negative limit.
		configure('0, GAIN_W'({$urandom, $urandom}), AMP_W'($urandom));
		queue_random_tones(30);
		repeat (130) queue_cmd(CMD_LOAD, FREQ_W'($urandom), '1);
		queue_cmd(CMD_TICK, '0, '0);
		wait_for_idle();

		// A one-unit period with the drift still at its limit: the longest possible
		// tone, where each tick adds a sample right back.
		configure(16'd1, GAIN_W'({$urandom, $urandom}), '1);
		write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
		queue_cmd(CMD_LOAD, FREQ_W'($urandom), '1);
		repeat (5) queue_cmd(CMD_TICK, '0, '0);
		queue_random_tones(60);
		wait_for_idle();

		// Random settings.
		repeat (1) begin
			configure(PER_W'($urandom_range(125, 65535)), GAIN_W'({$urandom, $urandom}),
				AMP_W'($urandom));
			queue_random_tones(100);
			wait_for_idle();
		end

		if (errors == 0) begin
			$display("balanced_duration_tone_generator test passed");
		end else begin
			$display("balanced_duration_tone_generator test failed");
		end
		$finish;
	end

endmodule
